>>> src/ssfs_pkg.sv
`default_nettype none

package ssfs_pkg;

  // grid and field widths
  localparam int GRID_BITS = 8;
  localparam int DIM_W     = 13;
  localparam int EDGE_W    = 20;
  localparam int SUM_W     = 21;
  localparam int DELAY_W   = 32;
  localparam int TICK_W    = 24;
  localparam int PLAYS_W   = 16;
  localparam int ACC_W     = 33;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  // divider step counter holds 0..ACC_W
  localparam int DIV_CNT_W = $clog2(ACC_W + 1);

  // 1.0 s in Q16.16, used when the frame delay is zero
  localparam logic [DELAY_W-1:0] ONE_SECOND = DELAY_W'(65536);

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 2'd0,
    CMD_PLAY   = 2'd1,
    CMD_STOP   = 2'd2,
    CMD_REWIND = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_FIRST_ROW    = 3'd2,
    CFG_LAST_ROW     = 3'd3,
    CFG_LAST_COLUMN  = 3'd4,
    CFG_FRAME_DELAY  = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_TIME,
    ST_DIV_CYCLE,
    ST_STEP,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

>>> src/sprite_sheet_frame_sequencer_top.sv
`default_nettype none

// Sprite-sheet frame sequencer. Each input transfer carries one command (tick, play, stop,
// rewind) and yields exactly one result transfer with the current row/column, the source
// rectangle of the frame and the remaining play count. A tick adds its Q8.16 time to a Q17.16
// accumulator, divides by the frame delay (zero delay acts as 1.0 s) and advances that many
// frames, keeping the remainder. All work runs through one shared 33-bit restoring divider
// (one quotient bit per cycle) and a row stepper that moves one row per cycle, so the block
// takes one item at a time and in_ready_o is low while it works. Play, stop, rewind and a
// tick with no plays left go straight to the result step. A tick first runs the divider,
// then steps rows towards the end row; when a wrap leaves frames over, the divider runs
// once more on the cycle length and up to 256 more row steps follow. The result sits in
// an output register, so the next command is accepted
// while a result still waits for out_ready_i. Configuration writes are always taken and
// must only happen while the block is idle.
module sprite_sheet_frame_sequencer_top
  import ssfs_pkg::*;
(
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,

  // configuration writes
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [CFG_DAT_W-1:0]        cfg_data_i,

  // command channel
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [CMD_W-1:0]            cmd_i,
  input  wire logic [TICK_W-1:0]           tick_time_i,
  input  wire logic signed [PLAYS_W-1:0]   repeat_count_i,

  // result channel
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic                             status_o,
  output logic [GRID_BITS-1:0]             row_now_o,
  output logic [GRID_BITS-1:0]             column_now_o,
  output logic [EDGE_W-1:0]                source_left_o,
  output logic [EDGE_W-1:0]                source_top_o,
  output logic [SUM_W-1:0]                 source_right_o,
  output logic [SUM_W-1:0]                 source_bottom_o,
  output logic                             is_playing_o,
  output logic signed [PLAYS_W-1:0]        plays_left_o
);

  // ---------------------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------------------

  state_e                      state_q, state_d;

  // configuration
  logic [DIM_W-1:0]            frame_width_q, frame_width_d;
  logic [DIM_W-1:0]            frame_height_q, frame_height_d;
  logic [GRID_BITS-1:0]        first_row_q, first_row_d;
  logic [GRID_BITS-1:0]        last_row_q, last_row_d;
  logic [GRID_BITS-1:0]        last_column_q, last_column_d;
  logic [DELAY_W-1:0]          frame_delay_q, frame_delay_d;

  // animation state
  logic [ACC_W-1:0]            acc_q, acc_d;
  logic [GRID_BITS-1:0]        row_q, row_d;
  logic [GRID_BITS-1:0]        col_q, col_d;
  logic signed [PLAYS_W-1:0]   plays_q, plays_d;
  logic [EDGE_W-1:0]           left_q, left_d;
  logic [EDGE_W-1:0]           top_q, top_d;

  // frames still to advance
  logic [ACC_W-1:0]            n_q, n_d;

  // shared divider: partial remainder, dividend/quotient, divisor, step count
  logic [ACC_W-1:0]            rem_q, rem_d;
  logic [ACC_W-1:0]            quo_q, quo_d;
  logic [ACC_W-1:0]            dvs_q, dvs_d;
  logic [DIV_CNT_W-1:0]        cnt_q, cnt_d;

  // pending status of the command in flight
  logic                        status_q, status_d;

  // result register
  logic                        out_valid_q, out_valid_d;
  logic                        res_status_q, res_status_d;
  logic [GRID_BITS-1:0]        res_row_q, res_row_d;
  logic [GRID_BITS-1:0]        res_col_q, res_col_d;
  logic [EDGE_W-1:0]           res_left_q, res_left_d;
  logic [EDGE_W-1:0]           res_top_q, res_top_d;
  logic [SUM_W-1:0]            res_right_q, res_right_d;
  logic [SUM_W-1:0]            res_bottom_q, res_bottom_d;
  logic                        res_playing_q, res_playing_d;
  logic signed [PLAYS_W-1:0]   res_plays_q, res_plays_d;

  // ---------------------------------------------------------------------------------------
  // shared arithmetic
  // ---------------------------------------------------------------------------------------

  logic                        in_xfer;
  logic                        out_free;
  cmd_e                        cmd;

  logic [DELAY_W-1:0]          delay_eff;
  logic [ACC_W-1:0]            acc_sum;

  logic [GRID_BITS+DIM_W-1:0]  start_prod;
  logic [EDGE_W-1:0]           start_top;

  logic [GRID_BITS-1:0]        col_gap;
  logic                        n_fits;
  logic [ACC_W-1:0]            n_rest;
  logic [GRID_BITS+DIM_W-1:0]  left_prod;
  logic [EDGE_W-1:0]           left_next;

  logic                        plays_pos;
  logic signed [PLAYS_W-1:0]   plays_dec;

  logic [GRID_BITS:0]          row_span;
  logic [GRID_BITS:0]          col_span;
  logic [2*GRID_BITS+1:0]      cyc_len;

  logic [ACC_W:0]              trial;
  logic [ACC_W:0]              trial_diff;
  logic                        trial_ge;
  logic                        div_busy;
  logic                        quo_ge_plays;

  // step decisions
  logic                        step_stop;
  logic                        step_wrap;
  logic                        wrap_more;

  assign in_xfer  = in_valid_i & in_ready_o;
  assign out_free = ~out_valid_q | out_ready_i;
  assign cmd      = cmd_e'(cmd_i);

  // zero delay stands for one second
  assign delay_eff = (frame_delay_q == '0) ? ONE_SECOND : frame_delay_q;
  // accumulator wraps at 33 bits
  assign acc_sum   = acc_q + ACC_W'(tick_time_i);

  // top edge of the start row
  assign start_prod = (GRID_BITS+DIM_W)'(first_row_q) * (GRID_BITS+DIM_W)'(frame_height_q);
  assign start_top  = EDGE_W'(start_prod);

  // frames left in the current row; a small count lands within the row
  assign col_gap   = last_column_q - col_q;
  assign n_fits    = (n_q <= ACC_W'(col_gap));
  assign n_rest    = n_q - (ACC_W'(col_gap) + ACC_W'(1));
  assign left_prod = (GRID_BITS+DIM_W)'(n_q[GRID_BITS-1:0]) * (GRID_BITS+DIM_W)'(frame_width_q);
  assign left_next = left_q + EDGE_W'(left_prod);

  assign plays_pos = (plays_q > 0);
  assign plays_dec = plays_pos ? PLAYS_W'(plays_q - 16'sd1) : plays_q;

  // frames in one full cycle: rows times columns
  assign row_span = (GRID_BITS+1)'(GRID_BITS'(last_row_q - first_row_q)) + (GRID_BITS+1)'(1);
  assign col_span = (GRID_BITS+1)'(last_column_q) + (GRID_BITS+1)'(1);
  assign cyc_len  = (2*GRID_BITS+2)'(row_span) * (2*GRID_BITS+2)'(col_span);

  // restoring divider, one quotient bit per cycle
  assign trial      = {rem_q, quo_q[ACC_W-1]};
  assign trial_ge   = (trial >= {1'b0, dvs_q});
  assign trial_diff = trial - {1'b0, dvs_q};
  assign div_busy   = (cnt_q != '0);

  // whole cycles cover all remaining plays
  assign quo_ge_plays = (quo_q >= {{(ACC_W-PLAYS_W){1'b0}}, plays_q});

  assign step_stop = (n_q == '0) || (plays_q == '0) || n_fits;
  assign step_wrap = (row_q == last_row_q);
  assign wrap_more = (n_rest != '0) && (plays_dec != '0);

  // ---------------------------------------------------------------------------------------
  // next state
  // ---------------------------------------------------------------------------------------

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if ((cmd == CMD_TICK) && (plays_q != '0)) begin
            state_d = ST_DIV_TIME;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DIV_TIME: begin
        if (!div_busy) begin
          state_d = ST_STEP;
        end
      end
      ST_DIV_CYCLE: begin
        if (!div_busy) begin
          if (plays_pos && quo_ge_plays) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_STEP;
          end
        end
      end
      ST_STEP: begin
        if (step_stop) begin
          state_d = ST_DONE;
        end else if (step_wrap) begin
          state_d = wrap_more ? ST_DIV_CYCLE : ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------------------
  // handshake outputs
  // ---------------------------------------------------------------------------------------

  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    cfg_ready_o = 1'b1;
    out_valid_o = out_valid_q;
  end

  // ---------------------------------------------------------------------------------------
  // datapath
  // ---------------------------------------------------------------------------------------

  always_comb begin
    frame_width_d  = frame_width_q;
    frame_height_d = frame_height_q;
    first_row_d    = first_row_q;
    last_row_d     = last_row_q;
    last_column_d  = last_column_q;
    frame_delay_d  = frame_delay_q;

    acc_d    = acc_q;
    row_d    = row_q;
    col_d    = col_q;
    plays_d  = plays_q;
    left_d   = left_q;
    top_d    = top_q;
    n_d      = n_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    dvs_d    = dvs_q;
    cnt_d    = cnt_q;
    status_d = status_q;

    out_valid_d   = out_valid_q & ~out_ready_i;
    res_status_d  = res_status_q;
    res_row_d     = res_row_q;
    res_col_d     = res_col_q;
    res_left_d    = res_left_q;
    res_top_d     = res_top_q;
    res_right_d   = res_right_q;
    res_bottom_d  = res_bottom_q;
    res_playing_d = res_playing_q;
    res_plays_d   = res_plays_q;

    // configuration transfer
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_FRAME_WIDTH:  frame_width_d  = DIM_W'(cfg_data_i);
        CFG_FRAME_HEIGHT: frame_height_d = DIM_W'(cfg_data_i);
        CFG_FIRST_ROW:    first_row_d    = GRID_BITS'(cfg_data_i);
        CFG_LAST_ROW:     last_row_d     = GRID_BITS'(cfg_data_i);
        CFG_LAST_COLUMN:  last_column_d  = GRID_BITS'(cfg_data_i);
        CFG_FRAME_DELAY:  frame_delay_d  = DELAY_W'(cfg_data_i);
        default: ;
      endcase
    end

    // divider shift step
    if (((state_q == ST_DIV_TIME) || (state_q == ST_DIV_CYCLE)) && div_busy) begin
      rem_d = trial_ge ? trial_diff[ACC_W-1:0] : trial[ACC_W-1:0];
      quo_d = {quo_q[ACC_W-2:0], trial_ge};
      cnt_d = cnt_q - DIV_CNT_W'(1);
    end

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          status_d = 1'b0;
          unique case (cmd)
            CMD_TICK: begin
              if (plays_q != '0) begin
                rem_d = '0;
                quo_d = acc_sum;
                dvs_d = ACC_W'(delay_eff);
                cnt_d = DIV_CNT_W'(ACC_W);
              end
            end
            CMD_PLAY: begin
              if (repeat_count_i == '0) begin
                status_d = 1'b1;
              end else begin
                plays_d = repeat_count_i;
              end
            end
            CMD_STOP: begin
              plays_d = '0;
            end
            CMD_REWIND: begin
              row_d  = first_row_q;
              col_d  = '0;
              left_d = '0;
              top_d  = start_top;
              acc_d  = '0;
            end
            default: ;
          endcase
        end
      end

      ST_DIV_TIME: begin
        // remainder stays in the accumulator, quotient is the frame count
        if (!div_busy) begin
          acc_d = rem_q;
          n_d   = quo_q;
        end
      end

      ST_DIV_CYCLE: begin
        // skip whole cycles at once
        if (!div_busy) begin
          n_d = rem_q;
          if (plays_pos) begin
            if (quo_ge_plays) begin
              plays_d = '0;
            end else begin
              plays_d = PLAYS_W'(plays_q - signed'(quo_q[PLAYS_W-1:0]));
            end
          end
        end
      end

      ST_STEP: begin
        if ((n_q != '0) && (plays_q != '0)) begin
          if (n_fits) begin
            col_d  = col_q + n_q[GRID_BITS-1:0];
            left_d = left_next;
          end else begin
            n_d = n_rest;
            if (!step_wrap) begin
              // next row
              row_d  = row_q + GRID_BITS'(1);
              col_d  = '0;
              left_d = '0;
              top_d  = top_q + EDGE_W'(frame_height_q);
            end else begin
              // end of the cycle, back to the start frame
              row_d   = first_row_q;
              col_d   = '0;
              left_d  = '0;
              top_d   = start_top;
              plays_d = plays_dec;
              if (wrap_more) begin
                rem_d = '0;
                quo_d = n_rest;
                dvs_d = ACC_W'(cyc_len);
                cnt_d = DIV_CNT_W'(ACC_W);
              end
            end
          end
        end
      end

      ST_DONE: begin
        // snapshot into the result register once it is free
        if (out_free) begin
          out_valid_d   = 1'b1;
          res_status_d  = status_q;
          res_row_d     = row_q;
          res_col_d     = col_q;
          res_left_d    = left_q;
          res_top_d     = top_q;
          res_right_d   = SUM_W'(left_q) + SUM_W'(frame_width_q);
          res_bottom_d  = SUM_W'(top_q) + SUM_W'(frame_height_q);
          res_playing_d = (plays_q != '0);
          res_plays_d   = plays_q;
        end
      end

      default: ;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      frame_width_q  <= DIM_W'(1);
      frame_height_q <= DIM_W'(1);
      first_row_q    <= '0;
      last_row_q     <= '0;
      last_column_q  <= '0;
      frame_delay_q  <= ONE_SECOND;
      acc_q          <= '0;
      row_q          <= '0;
      col_q          <= '0;
      plays_q        <= '0;
      left_q         <= '0;
      top_q          <= '0;
      cnt_q          <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      frame_width_q  <= frame_width_d;
      frame_height_q <= frame_height_d;
      first_row_q    <= first_row_d;
      last_row_q     <= last_row_d;
      last_column_q  <= last_column_d;
      frame_delay_q  <= frame_delay_d;
      acc_q          <= acc_d;
      row_q          <= row_d;
      col_q          <= col_d;
      plays_q        <= plays_d;
      left_q         <= left_d;
      top_q          <= top_d;
      cnt_q          <= cnt_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // working and result payload
  always_ff @(posedge clk_i) begin
    n_q           <= n_d;
    rem_q         <= rem_d;
    quo_q         <= quo_d;
    dvs_q         <= dvs_d;
    status_q      <= status_d;
    res_status_q  <= res_status_d;
    res_row_q     <= res_row_d;
    res_col_q     <= res_col_d;
    res_left_q    <= res_left_d;
    res_top_q     <= res_top_d;
    res_right_q   <= res_right_d;
    res_bottom_q  <= res_bottom_d;
    res_playing_q <= res_playing_d;
    res_plays_q   <= res_plays_d;
  end

  assign status_o        = res_status_q;
  assign row_now_o       = res_row_q;
  assign column_now_o    = res_col_q;
  assign source_left_o   = res_left_q;
  assign source_top_o    = res_top_q;
  assign source_right_o  = res_right_q;
  assign source_bottom_o = res_bottom_q;
  assign is_playing_o    = res_playing_q;
  assign plays_left_o    = res_plays_q;

endmodule

`default_nettype wire
